// ----- hdl/two_fragment_reassembly_table_top_defines.svh -----
// Assertion macros shared by the reassembly table RTL.
`ifndef TWO_FRAGMENT_REASSEMBLY_TABLE_TOP_DEFINES_SVH
`define TWO_FRAGMENT_REASSEMBLY_TABLE_TOP_DEFINES_SVH

`ifndef SYNTH
// Checked property, disabled while reset is asserted.
`define TFRT_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checked property, also active during reset.
`define TFRT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define TFRT_ASSERT(lbl, clk, rst_n, prop, msg)
`define TFRT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- hdl/tfrt_pkg.sv -----
// Types and constants of the two-fragment reassembly table.
`timescale 1ns / 1ps
`default_nettype none
package tfrt_pkg;

	localparam int FIELD_W = 64;
	localparam int FRAME_W = 8;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CMP,
		ST_FINISH
	} fsm_state_t;

	// Commands from the sequencer to the pending-flag bank.
	typedef struct packed {
		logic alloc;       // set pending at write pointer, advance pointer
		logic release_hit; // clear pending at the given index
		logic visit;       // mark the given index as examined in this search
		logic scan_clear;  // start a new search
	} pend_ctl_t;

endpackage
`default_nettype wire

// ----- hdl/two_fragment_reassembly_table_top.sv -----
// Top level of the two-fragment reassembly table.
`timescale 1ns / 1ps
`default_nettype none
`include "two_fragment_reassembly_table_top_defines.svh"
// Rejoins packets sent as two fragments. A transfer with frame number 0 stores
// its serial and first payload at the round-robin write pointer and marks that
// entry pending; any other frame number looks for the lowest pending entry with
// the same serial, clears it on a hit and returns the joined packet. Each input
// transfer gives exactly one output transfer (all zero unless complete). One
// item is worked on at a time. A later fragment examines the pending entries
// one after another, at most ENTRIES of them, as the single read port of the
// entry RAM returns one candidate per cycle. Pending flags sit in flip-flops
// cleared by reset, so no clearing pass is needed. A new item is accepted
// while the previous result still waits in the output register.
module two_fragment_reassembly_table_top #(
	parameter int ENTRIES      = 8,
	parameter int SERIAL_BYTES = 8,
	parameter int FIRST_BYTES  = 8,
	parameter int SECOND_BYTES = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [127:0] s_tdata,  // sender_serial[63:0], fragment_payload[127:64]
	input  wire logic [7:0]   s_tuser,  // frame_number[7:0]
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic      [191:0] m_tdata,  // origin_serial[63:0], first_part[127:64],
	                                    // second_part[191:128]
	output logic      [0:0]   m_tuser   // complete[0]
);
	import tfrt_pkg::*;

	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int SER_W   = 8 * SERIAL_BYTES;
	localparam int FIRST_W = 8 * FIRST_BYTES;
	localparam int SEC_W   = 8 * SECOND_BYTES;
	localparam int RAM_W   = SER_W + FIRST_W;
	localparam logic [FIELD_W-1:0] SEC_MASK = ~({FIELD_W{1'b1}} >> SEC_W);

	fsm_state_t state_q, state_d;

	logic               first_q;
	logic [SER_W-1:0]   ser_q;
	logic [FIELD_W-1:0] pay_q;
	logic [IDX_W-1:0]   cur_idx_q;
	logic               hit_q;
	logic [FIRST_W-1:0] hit_first_q;

	logic               m_tvalid_q;
	logic [191:0]       m_tdata_q;
	logic [0:0]         m_tuser_q;

	logic               accept;
	logic               out_free;
	logic               match;
	logic               issue;
	logic               finish;
	pend_ctl_t          ctl;
	logic [IDX_W-1:0]   pend_idx;
	logic [IDX_W-1:0]   wp;
	logic               cand_valid;
	logic [IDX_W-1:0]   cand_idx;
	logic [RAM_W-1:0]   ram_wdata;
	logic [RAM_W-1:0]   ram_rdata;
	logic [SER_W-1:0]   rd_ser;
	logic [FIRST_W-1:0] rd_first;
	logic [FIELD_W-1:0] origin_w;
	logic [FIELD_W-1:0] first_w;

	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign rd_ser   = ram_rdata[FIRST_W +: SER_W];
	assign rd_first = ram_rdata[FIRST_W-1:0];
	assign match    = (rd_ser == ser_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = (s_tuser == '0) ? ST_FINISH : ST_SCAN;
				end
			end
			ST_SCAN: begin
				state_d = cand_valid ? ST_CMP : ST_FINISH;
			end
			ST_CMP: begin
				if (match || !cand_valid) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_tready = 1'b0;
		issue    = 1'b0;
		finish   = 1'b0;
		unique case (state_q)
			ST_IDLE:   s_tready = 1'b1;
			ST_SCAN:   issue    = cand_valid;
			ST_CMP:    issue    = !match && cand_valid;
			ST_FINISH: finish   = out_free;
			default: ;
		endcase
		ctl.scan_clear  = accept;
		ctl.visit       = issue;
		ctl.alloc       = finish && first_q;
		ctl.release_hit = finish && hit_q;
		pend_idx        = ctl.release_hit ? cur_idx_q : cand_idx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
			hit_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (finish) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (accept) begin
				hit_q <= 1'b0;
			end else if (state_q == ST_CMP && match) begin
				hit_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			first_q <= (s_tuser == '0);
			ser_q   <= s_tdata[FIELD_W-1 -: SER_W];
			pay_q   <= s_tdata[2*FIELD_W-1:FIELD_W];
		end
		if (issue) begin
			cur_idx_q <= cand_idx;
		end
		if (state_q == ST_CMP && match) begin
			hit_first_q <= rd_first;
		end
		if (finish) begin
			m_tuser_q <= hit_q;
			if (hit_q) begin
				m_tdata_q <= {pay_q & SEC_MASK, first_w, origin_w};
			end else begin
				m_tdata_q <= '0;
			end
		end
	end

	// kept bytes back to their leading positions
	always_comb begin
		origin_w                      = '0;
		origin_w[FIELD_W-1 -: SER_W]  = ser_q;
		first_w                       = '0;
		first_w[FIELD_W-1 -: FIRST_W] = hit_first_q;
	end

	assign ram_wdata = {ser_q, pay_q[FIELD_W-1 -: FIRST_W]};

	tfrt_ram #(
		.WIDTH (RAM_W),
		.DEPTH (ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ctl.alloc),
		.waddr (wp),
		.wdata (ram_wdata),
		.re    (issue),
		.raddr (cand_idx),
		.rdata (ram_rdata)
	);

	tfrt_pend #(
		.ENTRIES (ENTRIES)
	) u_pend (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.idx        (pend_idx),
		.wp         (wp),
		.cand_valid (cand_valid),
		.cand_idx   (cand_idx)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	`TFRT_ASSERT(a_one_item, clk, arst_n, accept |=> !s_tready, "second item taken while busy")
	`TFRT_ASSERT(a_result_out, clk, arst_n, finish |=> m_tvalid, "finished result not presented")
	`TFRT_ASSERT(a_store_no_hit, clk, arst_n, ctl.alloc |-> !hit_q, "first fragment flagged as hit")

endmodule
`default_nettype wire

// ----- hdl/tfrt_ram.sv -----
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module tfrt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ----- hdl/tfrt_pend.sv -----
// Pending flags, round-robin write pointer and lowest-candidate search.
`timescale 1ns / 1ps
`default_nettype none
`include "two_fragment_reassembly_table_top_defines.svh"
module tfrt_pend #(
	parameter int ENTRIES = 8,
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire tfrt_pkg::pend_ctl_t ctl,
	input  wire logic [IDX_W-1:0]   idx,
	output logic      [IDX_W-1:0]   wp,
	output logic                    cand_valid,
	output logic      [IDX_W-1:0]   cand_idx
);
	import tfrt_pkg::*;

	logic [ENTRIES-1:0] pend_q;
	logic [ENTRIES-1:0] visited_q;
	logic [IDX_W-1:0]   wp_q;
	logic [ENTRIES-1:0] avail;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q    <= '0;
			visited_q <= '0;
			wp_q      <= '0;
		end else begin
			if (ctl.alloc) begin
				pend_q[wp_q] <= 1'b1;
				if (wp_q == IDX_W'(ENTRIES - 1)) begin
					wp_q <= '0;
				end else begin
					wp_q <= wp_q + 1'b1;
				end
			end
			if (ctl.release_hit) begin
				pend_q[idx] <= 1'b0;
			end
			if (ctl.scan_clear) begin
				visited_q <= '0;
			end else if (ctl.visit) begin
				visited_q[idx] <= 1'b1;
			end
		end
	end

	// lowest pending entry not yet examined in this search
	always_comb begin
		avail    = pend_q & ~visited_q;
		cand_idx = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (avail[i]) begin
				cand_idx = IDX_W'(i);
			end
		end
		cand_valid = |avail;
	end

	assign wp = wp_q;

	`TFRT_ASSERT(a_release_pending, clk, arst_n, ctl.release_hit |-> pend_q[idx], "release of idle entry")
	`TFRT_ASSERT(a_visit_cand, clk, arst_n, ctl.visit |-> (cand_valid && idx == cand_idx), "visit off candidate")
	`TFRT_ASSERT(a_alloc_sets, clk, arst_n, ctl.alloc |=> pend_q[$past(wp_q)], "alloc did not mark pending")

endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
// Self-checking testbench for the two-fragment reassembly table.
`timescale 1ns / 1ps
module tb_top;
	import tfrt_pkg::*;

	localparam int ENTRIES      = 8;
	localparam int SERIAL_BYTES = 8;
	localparam int FIRST_BYTES  = 8;
	localparam int SECOND_BYTES = 8;
	localparam logic [FRAME_W-1:0] FIRST_FRAME = '0;
	localparam logic [FIELD_W-1:0] ALL_ONES = '1;

	typedef struct packed {
		logic               complete;
		logic [FIELD_W-1:0] origin;
		logic [FIELD_W-1:0] first;
		logic [FIELD_W-1:0] second;
	} joined_t;

	logic         clk;
	logic         arst_n   = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [127:0] s_tdata  = '0;  // sender_serial[63:0], fragment_payload[127:64]
	logic [7:0]   s_tuser  = '0;  // frame_number[7:0]
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [191:0] m_tdata;        // origin_serial[63:0], first_part[127:64], second_part[191:128]
	logic [0:0]   m_tuser;        // complete[0]

	int src_idle_pct = 0;
	int snk_idle_pct = 0;
	int error_count  = 0;

	// Predicted table contents
	logic               entry_pending [ENTRIES];
	logic [FIELD_W-1:0] entry_serial  [ENTRIES];
	logic [FIELD_W-1:0] entry_first   [ENTRIES];
	int                 alloc_ptr;
	joined_t            joined_q[$];

	two_fragment_reassembly_table_top #(
		.ENTRIES     (ENTRIES),
		.SERIAL_BYTES(SERIAL_BYTES),
		.FIRST_BYTES (FIRST_BYTES),
		.SECOND_BYTES(SECOND_BYTES)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("tb_top: done, errors");
		$finish;
	end

	// keeps the leading nbytes bytes of a word
	function automatic logic [FIELD_W-1:0] lead_mask(int nbytes);
		int n = nbytes;
		if (n < 1) n = 1;
		if (n >= 8) return ALL_ONES;
		return ~(ALL_ONES >> (8 * n));
	endfunction

	function automatic joined_t join_fragment(logic [FRAME_W-1:0] frame,
		logic [FIELD_W-1:0] serial, logic [FIELD_W-1:0] payload);
		joined_t            res = '0;
		logic [FIELD_W-1:0] key = serial & lead_mask(SERIAL_BYTES);
		bit                 hit = 0;
		if (frame == FIRST_FRAME) begin
			entry_pending[alloc_ptr] = 1'b1;
			entry_serial[alloc_ptr]  = key;
			entry_first[alloc_ptr]   = payload & lead_mask(FIRST_BYTES);
			alloc_ptr = (alloc_ptr + 1 >= ENTRIES) ? 0 : alloc_ptr + 1;
		end else begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (!hit && entry_pending[i] && entry_serial[i] == key) begin
					hit              = 1;
					entry_pending[i] = 1'b0;
					res.complete     = 1'b1;
					res.origin       = entry_serial[i];
					res.first        = entry_first[i];
					res.second       = payload & lead_mask(SECOND_BYTES);
				end
			end
		end
		return res;
	endfunction

	task automatic send_fragment(logic [FRAME_W-1:0] frame, logic [FIELD_W-1:0] serial,
		logic [FIELD_W-1:0] payload);
		if ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= frame;
		s_tdata  <= {payload, serial};
		do @(posedge clk); while (!s_tready);
		joined_q.push_back(join_fragment(frame, serial, payload));
	endtask

	function automatic logic [FIELD_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Output side: random stalls, compare each transfer against the oldest prediction
	always @(posedge clk) begin
		joined_t want;
		joined_t got;
		if (m_tvalid && m_tready) begin
			got = {m_tuser[0], m_tdata[63:0], m_tdata[127:64], m_tdata[191:128]};
			if (joined_q.size() == 0) begin
				$display("%0t: unexpected result, actual %h", $realtime, got);
				error_count++;
			end else begin
				want = joined_q.pop_front();
				if (got.complete !== want.complete) begin
					$display("%0t: complete expected %b actual %b",
						$realtime, want.complete, got.complete);
					error_count++;
				end
				if (got.origin !== want.origin) begin
					$display("%0t: origin_serial expected %h actual %h",
						$realtime, want.origin, got.origin);
					error_count++;
				end
				if (got.first !== want.first) begin
					$display("%0t: first_part expected %h actual %h",
						$realtime, want.first, got.first);
					error_count++;
				end
				if (got.second !== want.second) begin
					$display("%0t: second_part expected %h actual %h",
						$realtime, want.second, got.second);
					error_count++;
				end
			end
		end
		m_tready <= ($urandom_range(99) >= snk_idle_pct);
	end

	task automatic test_unmatched_on_empty();
		send_fragment(8'd1, rand64(), rand64());
	endtask

	task automatic test_field_extremes();
		send_fragment(FIRST_FRAME, '0, ALL_ONES);
		send_fragment(FIRST_FRAME, ALL_ONES, '0);
		send_fragment(8'hFF, ALL_ONES, ALL_ONES);
		send_fragment(8'd1, '0, '0);
		// entry already released, so this one misses
		send_fragment(8'd1, '0, ALL_ONES);
	endtask

	task automatic test_same_serial();
		logic [FIELD_W-1:0] key = rand64();
		send_fragment(FIRST_FRAME, key, rand64());
		send_fragment(FIRST_FRAME, key, rand64());
		send_fragment(8'h80, key, rand64());
		send_fragment(8'h7F, key, rand64());
	endtask

	// fill every entry, then overwrite the oldest one while still pending
	task automatic test_pointer_wrap();
		logic [FIELD_W-1:0] keys [ENTRIES];
		logic [FIELD_W-1:0] late_key = rand64();
		for (int i = 0; i < ENTRIES; i++) begin
			keys[i] = rand64();
			send_fragment(FIRST_FRAME, keys[i], rand64());
		end
		send_fragment(FIRST_FRAME, late_key, rand64());
		send_fragment(8'd2, keys[0], rand64());
		send_fragment(8'd3, late_key, rand64());
	endtask

	task automatic test_random_traffic(int count);
		logic [FIELD_W-1:0] pool [10];
		int                 pick;
		for (int i = 0; i < 10; i++) pool[i] = rand64();
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if (pick < 45)
				send_fragment(FIRST_FRAME, pool[4'($urandom_range(9))], rand64());
			else if (pick < 90)
				send_fragment(8'($urandom_range(1, 255)), pool[4'($urandom_range(9))],
					rand64());
			else if (pick < 95)
				send_fragment(8'($urandom_range(1, 255)), rand64(), rand64());
			else
				send_fragment(FIRST_FRAME, rand64(), rand64());
		end
	endtask

	initial begin
		for (int i = 0; i < ENTRIES; i++) begin
			entry_pending[i] = 1'b0;
			entry_serial[i]  = '0;
			entry_first[i]   = '0;
		end
		alloc_ptr = 0;
		src_idle_pct <= 33;
		snk_idle_pct <= 68;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		test_unmatched_on_empty();
		test_field_extremes();
		test_same_serial();
		test_pointer_wrap();
		test_random_traffic(267);

		src_idle_pct <= 68;
		snk_idle_pct <= 33;
		test_random_traffic(267);

		src_idle_pct <= 0;
		snk_idle_pct <= 0;
		test_random_traffic(266);
		s_tvalid <= 1'b0;

		while (joined_q.size() != 0) @(posedge clk);
		repeat (2 * ENTRIES + 8) @(posedge clk);
		if (error_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end
endmodule
